/* sv/ibs_pkg.sv */
// ----------------------------------------------------------------------------
// ibs_pkg: shared types and codes of the indexed byte stack
// Request kinds, status codes, sequencer states and field widths.
// ----------------------------------------------------------------------------
package ibs_pkg;

  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 3;
  localparam int POS_W    = 6;
  localparam int FILL_W   = 7;
  localparam int STATUS_W = 3;

  // Request kinds
  localparam logic [KIND_W-1:0] REQ_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] REQ_POP    = 3'd1;
  localparam logic [KIND_W-1:0] REQ_READ   = 3'd2;
  localparam logic [KIND_W-1:0] REQ_FIND   = 3'd3;
  localparam logic [KIND_W-1:0] REQ_REMOVE = 3'd4;
  localparam logic [KIND_W-1:0] REQ_WRITE  = 3'd5;
  localparam logic [KIND_W-1:0] REQ_CLEAR  = 3'd6;

  // Status codes
  localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] STS_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STS_BAD_INDEX = 3'd3;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd4;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_FIND,
    ST_SHIFT,
    ST_RESP
  } state_t;

endpackage

/* sv/ibs_ram.sv */
// ----------------------------------------------------------------------------
// ibs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ibs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/indexed_byte_stack.sv */
// Sequence: push, write, clear and every refused request go from exec straight to response;
//   pop and read pass through the read-data state; find walks down from the top until a hit
//   or the bottom; remove closes the gap in the shift state, one element moved per cycle.
// Flow: one request at a time, taken again once the sequencer is back in idle; find and
//   remove walk the single RAM read port one entry per cycle.
// Reset (synchronous, rst_n low): count to zero, sequencer to idle, output empty; store kept.
// ----------------------------------------------------------------------------
// indexed_byte_stack: byte stack with indexed access
// Push, pop, read, find, remove with gap closing, overwrite and clear over a
// RAM-backed store, driven by a small sequencer with scan and shift index counters.
// ----------------------------------------------------------------------------
module indexed_byte_stack #(
  parameter int STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] position, [13:6] byte_in, [15:14] zero
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] byte_out, [13:8] found_position,
                                  // [20:14] fill_count, [23:21] zero
  output logic [2:0]  out_tuser   // [2:0] status
);

  // address width of the store, count width (holds STACK_DEPTH itself), and a
  // common compare width wide enough for the count and the fixed output fields
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int XW = (CW > ibs_pkg::FILL_W) ? CW : ibs_pkg::FILL_W;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  ibs_pkg::state_t state_r, state_nxt;

  logic [ibs_pkg::KIND_W-1:0]   kind_r,  kind_nxt;
  logic [ibs_pkg::POS_W-1:0]    pos_r,   pos_nxt;
  logic [ibs_pkg::BYTE_W-1:0]   val_r,   val_nxt;
  logic [CW-1:0]                count_r, count_nxt;

  // scan state for find: next address to read, address whose data is arriving
  logic [AW-1:0]                scan_r,      scan_nxt;
  logic [AW-1:0]                cmp_idx_r,   cmp_idx_nxt;
  logic                         cmp_valid_r, cmp_valid_nxt;

  // shift state for remove: next source to read, pending write slot
  logic [CW-1:0]                src_r,         src_nxt;
  logic [AW-1:0]                wr_addr_r,     wr_addr_nxt;
  logic                         shift_valid_r, shift_valid_nxt;

  // result being built
  logic [ibs_pkg::BYTE_W-1:0]   res_byte_r,   res_byte_nxt;
  logic [ibs_pkg::POS_W-1:0]    res_found_r,  res_found_nxt;
  logic [ibs_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;

  // output register
  logic                         out_valid_r,  out_valid_nxt;
  logic [ibs_pkg::BYTE_W-1:0]   out_byte_r,   out_byte_nxt;
  logic [ibs_pkg::POS_W-1:0]    out_found_r,  out_found_nxt;
  logic [ibs_pkg::FILL_W-1:0]   out_fill_r,   out_fill_nxt;
  logic [ibs_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  // --------------------------------------------------------------------------
  // Store
  // --------------------------------------------------------------------------
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [ibs_pkg::BYTE_W-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [ibs_pkg::BYTE_W-1:0] ram_rdata;

  ibs_ram #(
    .WIDTH (ibs_pkg::BYTE_W),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Shared decisions
  // --------------------------------------------------------------------------
  logic          accept;
  logic          is_full;
  logic          is_empty;
  logic          bad_index;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] count_x;
  logic [XW-1:0] cmp_idx_x;
  logic          find_hit;
  logic          find_miss;
  logic          shift_more;
  logic          out_free;

  assign accept     = in_tvalid && in_tready;
  assign pos_x      = XW'(pos_r);
  assign count_x    = XW'(count_r);
  assign cmp_idx_x  = XW'(cmp_idx_r);
  assign is_full    = (count_x == XW'(STACK_DEPTH));
  assign is_empty   = (count_r == '0);
  assign bad_index  = (pos_x >= count_x);
  // data from the previous scan read is on ram_rdata this cycle
  assign find_hit   = cmp_valid_r && (ram_rdata == val_r);
  assign find_miss  = cmp_valid_r && (ram_rdata != val_r) && (cmp_idx_r == '0);
  assign shift_more = (src_r < count_r);
  assign out_free   = !out_valid_r || out_tready;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ibs_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = ibs_pkg::ST_EXEC;
        end
      end
      ibs_pkg::ST_EXEC: begin
        state_nxt = ibs_pkg::ST_RESP;
        case (kind_r)
          ibs_pkg::REQ_POP: begin
            if (!is_empty) state_nxt = ibs_pkg::ST_RDATA;
          end
          ibs_pkg::REQ_READ: begin
            if (!bad_index) state_nxt = ibs_pkg::ST_RDATA;
          end
          ibs_pkg::REQ_FIND: begin
            if (!is_empty) state_nxt = ibs_pkg::ST_FIND;
          end
          ibs_pkg::REQ_REMOVE: begin
            if (!bad_index) state_nxt = ibs_pkg::ST_SHIFT;
          end
          default: begin
            state_nxt = ibs_pkg::ST_RESP;
          end
        endcase
      end
      ibs_pkg::ST_RDATA: begin
        state_nxt = ibs_pkg::ST_RESP;
      end
      ibs_pkg::ST_FIND: begin
        if (find_hit || find_miss) begin
          state_nxt = ibs_pkg::ST_RESP;
        end
      end
      ibs_pkg::ST_SHIFT: begin
        if (!shift_more) begin
          state_nxt = ibs_pkg::ST_RESP;
        end
      end
      ibs_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = ibs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ibs_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs and datapath
  // --------------------------------------------------------------------------
  always_comb begin
    in_tready       = (state_r == ibs_pkg::ST_IDLE);

    kind_nxt        = kind_r;
    pos_nxt         = pos_r;
    val_nxt         = val_r;
    count_nxt       = count_r;
    scan_nxt        = scan_r;
    cmp_idx_nxt     = cmp_idx_r;
    cmp_valid_nxt   = cmp_valid_r;
    src_nxt         = src_r;
    wr_addr_nxt     = wr_addr_r;
    shift_valid_nxt = shift_valid_r;
    res_byte_nxt    = res_byte_r;
    res_found_nxt   = res_found_r;
    res_status_nxt  = res_status_r;

    out_byte_nxt    = out_byte_r;
    out_found_nxt   = out_found_r;
    out_fill_nxt    = out_fill_r;
    out_status_nxt  = out_status_r;
    out_valid_nxt   = out_tready ? 1'b0 : out_valid_r;

    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = val_r;
    ram_raddr       = '0;

    case (state_r)
      ibs_pkg::ST_IDLE: begin
        // capture the request
        if (accept) begin
          kind_nxt = in_tuser;
          pos_nxt  = in_tdata[5:0];
          val_nxt  = in_tdata[13:6];
        end
      end

      ibs_pkg::ST_EXEC: begin
        res_byte_nxt   = '0;
        res_found_nxt  = '0;
        res_status_nxt = ibs_pkg::STS_OK;
        case (kind_r)
          ibs_pkg::REQ_PUSH: begin
            if (is_full) begin
              res_status_nxt = ibs_pkg::STS_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
            end
          end
          ibs_pkg::REQ_POP: begin
            if (is_empty) begin
              res_status_nxt = ibs_pkg::STS_EMPTY;
            end else begin
              count_nxt = count_r - CW'(1);
              ram_raddr = count_nxt[AW-1:0];
            end
          end
          ibs_pkg::REQ_READ: begin
            if (bad_index) begin
              res_status_nxt = ibs_pkg::STS_BAD_INDEX;
            end else begin
              ram_raddr = pos_x[AW-1:0];
            end
          end
          ibs_pkg::REQ_FIND: begin
            // walk down from the top; empty stack reports not found
            if (is_empty) begin
              res_status_nxt = ibs_pkg::STS_NOT_FOUND;
            end else begin
              scan_nxt      = AW'(count_r - CW'(1));
              cmp_valid_nxt = 1'b0;
            end
          end
          ibs_pkg::REQ_REMOVE: begin
            if (bad_index) begin
              res_status_nxt = ibs_pkg::STS_BAD_INDEX;
            end else begin
              src_nxt         = CW'(pos_x + XW'(1));
              shift_valid_nxt = 1'b0;
            end
          end
          ibs_pkg::REQ_WRITE: begin
            if (bad_index) begin
              res_status_nxt = ibs_pkg::STS_BAD_INDEX;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = pos_x[AW-1:0];
            end
          end
          ibs_pkg::REQ_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
            // unused kind: answer ok, change nothing
            res_status_nxt = ibs_pkg::STS_OK;
          end
        endcase
      end

      ibs_pkg::ST_RDATA: begin
        res_byte_nxt = ram_rdata;
      end

      ibs_pkg::ST_FIND: begin
        // issue one read a cycle, compare the one that came back
        ram_raddr     = scan_r;
        scan_nxt      = scan_r - AW'(1);
        cmp_idx_nxt   = scan_r;
        cmp_valid_nxt = 1'b1;
        if (find_hit) begin
          res_found_nxt = cmp_idx_x[ibs_pkg::POS_W-1:0];
        end else if (find_miss) begin
          res_status_nxt = ibs_pkg::STS_NOT_FOUND;
        end
      end

      ibs_pkg::ST_SHIFT: begin
        // drop the element read last cycle one slot lower
        ram_we    = shift_valid_r;
        ram_waddr = wr_addr_r;
        ram_wdata = ram_rdata;
        if (shift_more) begin
          ram_raddr       = src_r[AW-1:0];
          wr_addr_nxt     = AW'(src_r - CW'(1));
          shift_valid_nxt = 1'b1;
          src_nxt         = src_r + CW'(1);
        end else begin
          shift_valid_nxt = 1'b0;
          count_nxt       = count_r - CW'(1);
        end
      end

      ibs_pkg::ST_RESP: begin
        // hold the result until the output register frees up
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = res_byte_r;
          out_found_nxt  = res_found_r;
          out_fill_nxt   = count_x[ibs_pkg::FILL_W-1:0];
          out_status_nxt = res_status_r;
        end
      end

      default: begin
        out_valid_nxt = out_valid_r;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequential
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ibs_pkg::ST_IDLE;
      count_r       <= '0;
      cmp_valid_r   <= 1'b0;
      shift_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      cmp_valid_r   <= cmp_valid_nxt;
      shift_valid_r <= shift_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    scan_r       <= scan_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    src_r        <= src_nxt;
    wr_addr_r    <= wr_addr_nxt;
    res_byte_r   <= res_byte_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_found_r  <= out_found_nxt;
    out_fill_r   <= out_fill_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_fill_r, out_found_r, out_byte_r};
  assign out_tuser  = out_status_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_x <= XW'(STACK_DEPTH))
    else $error("element count above stack depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ibs_pkg::ST_EXEC && kind_r == ibs_pkg::REQ_PUSH && !is_full)
      |=> (count_r == $past(count_r) + CW'(1)))
    else $error("accepted push did not grow the count");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ibs_pkg::ST_EXEC || state_r == ibs_pkg::ST_SHIFT))
    else $error("store written outside exec or shift");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ibs_pkg::ST_RESP))
    else $error("result raised without passing through response state");

  a_ready_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ibs_pkg::ST_FIND || state_r == ibs_pkg::ST_SHIFT) |-> !in_tready)
    else $error("request taken while a walk is in progress");

endmodule
